@@ rtl/core/gwm_pkg.sv @@
package gwm_pkg;

    // Fixed widths of the request and result fields
    localparam int REQ_IDX_BITS = 4;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int RES_IDX_BITS = 4;
    localparam int MASK_BITS = 16;
    localparam int COUNT_BITS = 5;

    // Largest request/resource count that the index and mask fields can reach
    localparam int FIELD_SLOTS = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 5'd31;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_OFFER = 1'b1
    } cmd_t;

endpackage

@@ rtl/core/gwm_argmax.sv @@
module gwm_argmax
    import gwm_pkg::*;
#(
    parameter int N = 16,
    parameter int W = 16
)
(
    input  logic [W-1:0]                    cand [N],
    output logic                            found,
    output logic [$clog2(2**$clog2(N))-1:0] best_idx
);

    localparam int LEAVES = 2**$clog2(N);
    localparam int IW = $clog2(LEAVES);

    logic [W-1:0]  node_w   [2*LEAVES];
    logic [IW-1:0] node_idx [2*LEAVES];

    // Compare tree: a right (higher index) child wins only when strictly larger
    always_comb
    begin
        node_w[0] = '0;
        node_idx[0] = '0;
        for (int k = 0; k < LEAVES; k++)
        begin
            node_w[LEAVES + k] = (k < N) ? cand[k] : '0;
            node_idx[LEAVES + k] = IW'(k);
        end
        for (int i = LEAVES - 1; i >= 1; i--)
        begin
            if (node_w[2*i + 1] > node_w[2*i])
            begin
                node_w[i] = node_w[2*i + 1];
                node_idx[i] = node_idx[2*i + 1];
            end
            else
            begin
                node_w[i] = node_w[2*i];
                node_idx[i] = node_idx[2*i];
            end
        end
    end

    assign found = (node_w[1] != '0);
    assign best_idx = node_idx[1];

endmodule

@@ rtl/core/greedy_max_weight_matcher.sv @@
// A request is captured in the input register when accepted and shows its result (done
// high) from the result register behind it.
// Throughput: one request per cycle; busy stays low, so start may be held high every cycle.
// The receiver cannot stall: every result is on the ports for exactly one cycle.
// Reset (rst_n low, asynchronous) clears all weights, link flags and the match count.
module greedy_max_weight_matcher
    import gwm_pkg::*;
#(
    parameter int NUM_REQUESTS = 16,
    parameter int NUM_RESOURCES = 16,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cmd,
    input  logic [REQ_IDX_BITS-1:0] request_index,
    input  logic [WEIGHT_IN_BITS-1:0] weight,
    input  logic [RES_IDX_BITS-1:0] resource_index,
    input  logic [MASK_BITS-1:0]    edge_mask,
    output logic                    done,
    output logic                    granted,
    output logic [REQ_IDX_BITS-1:0] granted_request,
    output logic [COUNT_BITS-1:0]   match_count
);

    // Only indices the 4-bit fields and the 16-bit mask can name are ever used,
    // so storage is cut at the field range.
    localparam int REQ_USED = (NUM_REQUESTS < FIELD_SLOTS) ? NUM_REQUESTS : FIELD_SLOTS;
    localparam int RES_USED = (NUM_RESOURCES < FIELD_SLOTS) ? NUM_RESOURCES : FIELD_SLOTS;
    localparam int REQ_IDX_W = $clog2(REQ_USED);
    localparam int RES_IDX_W = $clog2(RES_USED);

    // ------------------------------------------------------------------
    // Input register: capture every accepted request
    // ------------------------------------------------------------------
    logic                      in_valid_reg;
    cmd_t                      cmd_reg;
    logic [REQ_IDX_BITS-1:0]   req_idx_reg;
    logic [WEIGHT_BITS-1:0]    weight_reg;
    logic [RES_IDX_BITS-1:0]   res_idx_reg;
    logic [MASK_BITS-1:0]      mask_reg;

    logic accept;

    // The datapath takes a new request every cycle
    assign busy = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    // Payload needs no reset; hold it when nothing is accepted
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            req_idx_reg <= request_index;
            // Keep only the low WEIGHT_BITS bits (zero-extend if wider)
            weight_reg <= WEIGHT_BITS'(weight);
            res_idx_reg <= resource_index;
            mask_reg <= edge_mask;
        end
    end

    // ------------------------------------------------------------------
    // Matcher state
    // ------------------------------------------------------------------
    logic [WEIGHT_BITS-1:0] weight_q_reg [REQ_USED];
    logic [WEIGHT_BITS-1:0] weight_q_next [REQ_USED];
    logic [REQ_USED-1:0]    req_linked_reg;
    logic [REQ_USED-1:0]    req_linked_next;
    logic [RES_USED-1:0]    res_linked_reg;
    logic [RES_USED-1:0]    res_linked_next;
    logic [COUNT_BITS-1:0]  links_made_reg;
    logic [COUNT_BITS-1:0]  links_made_next;

    // ------------------------------------------------------------------
    // Masked maximum search over the stored weights
    // ------------------------------------------------------------------
    logic [WEIGHT_BITS-1:0] cand [REQ_USED];
    logic                   found;
    logic [REQ_IDX_W-1:0]   best_idx;

    always_comb
    begin
        for (int r = 0; r < REQ_USED; r++)
        begin
            cand[r] = mask_reg[r] ? weight_q_reg[r] : '0;
        end
    end

    gwm_argmax #(
        .N (REQ_USED),
        .W (WEIGHT_BITS)
    ) u_argmax (
        .cand     (cand),
        .found    (found),
        .best_idx (best_idx)
    );

    // ------------------------------------------------------------------
    // Grant decision and state update
    // ------------------------------------------------------------------
    logic                 is_load;
    logic                 is_offer;
    logic                 load_ok;
    logic                 res_ok;
    logic [REQ_IDX_W-1:0] load_idx;
    logic [RES_IDX_W-1:0] res_idx;
    logic                 grant;

    assign is_load  = in_valid_reg && (cmd_reg == CMD_LOAD);
    assign is_offer = in_valid_reg && (cmd_reg == CMD_OFFER);
    // Drop loads and offers whose index lies past the configured count
    assign load_ok  = (32'(req_idx_reg) < NUM_REQUESTS);
    assign res_ok   = (32'(res_idx_reg) < NUM_RESOURCES);
    assign load_idx = req_idx_reg[REQ_IDX_W-1:0];
    assign res_idx  = res_idx_reg[RES_IDX_W-1:0];

    // The chosen request is final: if it or the resource is busy, no grant
    assign grant = is_offer && res_ok && found
                   && !res_linked_reg[res_idx] && !req_linked_reg[best_idx];

    always_comb
    begin
        weight_q_next = weight_q_reg;
        req_linked_next = req_linked_reg;
        res_linked_next = res_linked_reg;
        links_made_next = links_made_reg;
        if (is_load && load_ok)
        begin
            weight_q_next[load_idx] = weight_reg;
        end
        if (grant)
        begin
            req_linked_next[best_idx] = 1'b1;
            res_linked_next[res_idx] = 1'b1;
            // Saturate the link count
            if (links_made_reg != COUNT_MAX)
            begin
                links_made_next = links_made_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < REQ_USED; r++)
            begin
                weight_q_reg[r] <= '0;
            end
            req_linked_reg <= '0;
            res_linked_reg <= '0;
            links_made_reg <= '0;
        end
        else
        begin
            weight_q_reg <= weight_q_next;
            req_linked_reg <= req_linked_next;
            res_linked_reg <= res_linked_next;
            links_made_reg <= links_made_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: one strobe per request, loads included
    // ------------------------------------------------------------------
    logic                    done_reg;
    logic                    granted_reg;
    logic [REQ_IDX_BITS-1:0] granted_request_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            granted_reg <= 1'b0;
            granted_request_reg <= '0;
        end
        else
        begin
            done_reg <= in_valid_reg;
            granted_reg <= grant;
            // Report request zero whenever nothing was granted
            granted_request_reg <= grant ? REQ_IDX_BITS'(best_idx) : '0;
        end
    end

    assign done = done_reg;
    assign granted = granted_reg;
    assign granted_request = granted_request_reg;
    // The count register already holds the post-request total while done is high
    assign match_count = links_made_reg;

endmodule

@@ verif/greedy_max_weight_matcher_tb.sv @@
`timescale 1ns / 1ps

module greedy_max_weight_matcher_tb;
    import gwm_pkg::*;

    // Sizes of the instance under test (the defaults of the block)
    localparam int NUM_REQ = 16;
    localparam int NUM_RES = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1130;

    // One request as the driver presents it
    typedef struct packed {
        cmd_t                      op;
        logic [REQ_IDX_BITS-1:0]   req;
        logic [WEIGHT_IN_BITS-1:0] wt;
        logic [RES_IDX_BITS-1:0]   res;
        logic [MASK_BITS-1:0]      mask;
        logic                      drain_first;   // hold until all results are in
    } match_req_t;

    // One result as the block reports it
    typedef struct packed {
        logic                    granted;
        logic [REQ_IDX_BITS-1:0] who;
        logic [COUNT_BITS-1:0]   count;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    match_req_t cur_req = '0;

    logic                    busy;
    logic                    done;
    logic                    granted;
    logic [REQ_IDX_BITS-1:0] granted_request;
    logic [COUNT_BITS-1:0]   match_count;

    // Requests still to be sent, and grants predicted but not yet seen
    match_req_t pending_reqs[$];
    grant_t     expected_grants[$];

    // Shadow of the matcher state
    logic [WEIGHT_IN_BITS-1:0] weight_tab[NUM_REQ];
    logic                      req_bound[NUM_REQ];
    logic                      res_bound[NUM_RES];
    logic [COUNT_BITS-1:0]     link_total;

    logic taken = 1'b0;
    int   n_sent = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;

    greedy_max_weight_matcher i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cur_req.op),
        .request_index   (cur_req.req),
        .weight          (cur_req.wt),
        .resource_index  (cur_req.res),
        .edge_mask       (cur_req.mask),
        .done            (done),
        .granted         (granted),
        .granted_request (granted_request),
        .match_count     (match_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic match_req_t load_req(input int req, input int wt);
        match_req_t it;
        it = '0;
        it.op = CMD_LOAD;
        it.req = req[REQ_IDX_BITS-1:0];
        it.wt = wt[WEIGHT_IN_BITS-1:0];
        it.res = RES_IDX_BITS'($urandom());
        it.mask = MASK_BITS'($urandom());
        return it;
    endfunction

    function automatic match_req_t offer_req(input int res, input int mask);
        match_req_t it;
        it = '0;
        it.op = CMD_OFFER;
        it.req = REQ_IDX_BITS'($urandom());
        it.wt = WEIGHT_IN_BITS'($urandom());
        it.res = res[RES_IDX_BITS-1:0];
        it.mask = mask[MASK_BITS-1:0];
        return it;
    endfunction

    // Append one request at the tail of the send queue
    task automatic enqueue_req(input match_req_t it);
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    // Draw a random request; weights lean toward zero, full scale and a few
    // shared values so that ties and empty candidate sets keep turning up
    function automatic match_req_t random_req();
        int pick;
        int wt;
        int mask;
        pick = $urandom_range(99);
        if (pick < 10)
            wt = 0;
        else if (pick < 15)
            wt = 16'hFFFF;
        else if (pick < 35)
            wt = $urandom_range(2) == 0 ? 16'h4000 : ($urandom_range(1) ? 16'h4001 : 16'hC000);
        else
            wt = $urandom_range(16'hFFFF);
        pick = $urandom_range(99);
        if (pick < 8)
            mask = 0;
        else if (pick < 16)
            mask = 16'hFFFF;
        else if (pick < 40)
            mask = 1 << $urandom_range(NUM_REQ - 1);
        else
            mask = $urandom_range(16'hFFFF);
        if ($urandom_range(1) == 0)
            return load_req($urandom_range(NUM_REQ - 1), wt);
        return offer_req($urandom_range(NUM_RES - 1), mask);
    endfunction

    // Apply one request to the shadow state and give the grant it should cause
    task automatic predict_grant(input match_req_t it, output grant_t g);
        logic [WEIGHT_IN_BITS-1:0] best_wt;
        logic [REQ_IDX_BITS-1:0]   best_idx;
        logic                      found;
        best_wt = '0;
        best_idx = '0;
        found = 1'b0;
        g = '0;
        if (it.op == CMD_LOAD)
        begin
            if (it.req < NUM_REQ)
                weight_tab[it.req] = it.wt;
        end
        else if (it.res < NUM_RES)
        begin
            // Strict compare keeps the lowest index on a tie
            for (int r = 0; r < NUM_REQ; r++)
            begin
                if (it.mask[r] && weight_tab[r] > best_wt)
                begin
                    best_wt = weight_tab[r];
                    best_idx = REQ_IDX_BITS'(r);
                    found = 1'b1;
                end
            end
            // Only the heaviest candidate is tried; a busy one blocks the grant
            if (found && !res_bound[it.res] && !req_bound[best_idx])
            begin
                req_bound[best_idx] = 1'b1;
                res_bound[it.res] = 1'b1;
                if (link_total < COUNT_MAX)
                    link_total = link_total + 1'b1;
                g.granted = 1'b1;
                g.who = best_idx;
            end
        end
        g.count = link_total;
    endtask

    // Driver: advance on acceptance, then present the next request or idle.
    // The idle rate goes from light to heavy to none as requests go out.
    always @(negedge clk)
    begin : drive
        logic go;
        int   idle_pct;
        go = 1'b0;
        if (rst_n)
        begin
            if (taken)
            begin
                pending_reqs.delete(0);
                n_sent++;
            end
            idle_pct = n_sent < 400 ? 13 : (n_sent < 800 ? 84 : 0);
            if (pending_reqs.size() > 0)
            begin
                if (!(pending_reqs[0].drain_first && expected_grants.size() != 0))
                    go = $urandom_range(99) >= idle_pct;
            end
            // Drive junk on the payload while start is low; the block must ignore it
            if (go)
                cur_req <= pending_reqs[0];
            else
                cur_req <= random_req();
            start <= go;
        end
    end

    // Monitor: check the oldest expectation on each result, then record
    // the request accepted at this edge
    always @(posedge clk)
    begin : monitor
        grant_t got;
        grant_t want;
        logic   fire;
        fire = rst_n && start && !busy;
        if (rst_n && done)
        begin
            got = '{granted: granted, who: granted_request, count: match_count};
            if (expected_grants.size() == 0)
            begin
                $display("%0t: result with nothing expected: granted=%0d request=%0d count=%0d",
                         $realtime, got.granted, got.who, got.count);
                mismatch_count++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $realtime, want.granted, want.who, want.count,
                             got.granted, got.who, got.count);
                    mismatch_count++;
                end
            end
        end
        if (fire)
        begin
            predict_grant(cur_req, want);
            expected_grants.insert(expected_grants.size(), want);
        end
        taken <= fire;
    end

    // Watchdog: count cycles with no request taken and no result seen
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        match_req_t it;
        for (int r = 0; r < NUM_REQ; r++)
        begin
            weight_tab[r] = '0;
            req_bound[r] = 1'b0;
        end
        for (int r = 0; r < NUM_RES; r++)
            res_bound[r] = 1'b0;
        link_total = '0;

        // Directed: all weights still zero, so a full mask finds no candidate
        enqueue_req(offer_req(0, 16'hFFFF));
        enqueue_req(load_req(0, 16'hFFFF));
        enqueue_req(load_req(15, 16'h0001));
        enqueue_req(load_req(5, 16'h0000));
        // Empty mask: no candidate
        enqueue_req(offer_req(0, 16'h0000));
        // Smallest weight still wins when alone
        enqueue_req(offer_req(15, 16'h8000));
        // Heaviest of three, one of them zero
        enqueue_req(offer_req(1, 16'h8021));
        // Chosen request already linked
        enqueue_req(offer_req(2, 16'h0001));
        // Tie on equal weights goes to the lower index
        enqueue_req(load_req(3, 16'h8000));
        enqueue_req(load_req(7, 16'h8000));
        enqueue_req(offer_req(3, 16'h0088));
        // Resource already linked, though request 7 is free
        enqueue_req(offer_req(3, 16'h0080));
        // Heaviest is linked; lighter free ones are not tried
        enqueue_req(offer_req(4, 16'h0089));
        // Only a zero weight in the mask
        enqueue_req(offer_req(4, 16'h0020));
        enqueue_req(load_req(5, 16'h0002));
        enqueue_req(offer_req(4, 16'h0020));
        // Reload over a linked request
        enqueue_req(load_req(15, 16'hFFFF));
        enqueue_req(offer_req(5, 16'h8000));

        // Random traffic; pause until drained before the first item and at each idle-rate change
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            it = random_req();
            it.drain_first = (n == 0) || (pending_reqs.size() == 400)
                             || (pending_reqs.size() == 800);
            enqueue_req(it);
        end

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
